// ----- design/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg: shared definitions for the escape-time unit
// Fixed-point format, saturation helper and the sequencer control store.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRACTION_BITS = 28;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int PIX_W         = 10;
    localparam int STEP_REG_W    = 31;
    localparam int ITER_W        = 16;
    localparam int COLOR_W       = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int STEP_W        = 4;

    // escape threshold 4.0 at 2*FRACTION_BITS fraction bits, all ones if it does not fit
    localparam int          THR_SHIFT = 2 * FRACTION_BITS + 2;
    localparam logic [63:0] ESC_THR   = (THR_SHIFT <= 63) ? (64'd1 << THR_SHIFT) : {64{1'b1}};

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_REAL_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd4;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LOOP = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DONE = 4'd8;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_PX_RSTEP,
        MUL_PY_ISTEP,
        MUL_ZR_ZR,
        MUL_ZI_ZI,
        MUL_ZR_ZI
    } t_mul_sel;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_EXIT,
        SEQ_GOTO,
        SEQ_EMIT
    } t_seq;

    typedef struct packed {
        t_mul_sel          mul_sel;
        logic              ld_cr;
        logic              ld_ci;
        logic              ld_sq;
        logic              ld_diff;
        logic              upd_z;
        t_seq              seq;
        logic [STEP_W-1:0] target;
    } t_uword;

    // control store: one word per step
    function automatic t_uword mbe_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{mul_sel: MUL_NONE, ld_cr: 1'b0, ld_ci: 1'b0, ld_sq: 1'b0, ld_diff: 1'b0,
              upd_z: 1'b0, seq: SEQ_GOTO, target: STEP_IDLE};
        unique case (step)
            4'd0: begin
                w.seq = SEQ_WAIT_IN;
            end
            4'd1: begin
                w.mul_sel = MUL_PX_RSTEP;
                w.seq     = SEQ_NEXT;
            end
            4'd2: begin
                w.mul_sel = MUL_PY_ISTEP;
                w.ld_cr   = 1'b1;
                w.seq     = SEQ_NEXT;
            end
            4'd3: begin
                w.ld_ci = 1'b1;
                w.seq   = SEQ_NEXT;
            end
            4'd4: begin
                w.mul_sel = MUL_ZR_ZR;
                w.seq     = SEQ_NEXT;
            end
            4'd5: begin
                w.mul_sel = MUL_ZI_ZI;
                w.ld_sq   = 1'b1;
                w.seq     = SEQ_NEXT;
            end
            4'd6: begin
                w.mul_sel = MUL_ZR_ZI;
                w.ld_diff = 1'b1;
                w.seq     = SEQ_EXIT;
                w.target  = STEP_DONE;
            end
            4'd7: begin
                w.upd_z  = 1'b1;
                w.seq    = SEQ_GOTO;
                w.target = STEP_LOOP;
            end
            4'd8: begin
                w.seq    = SEQ_EMIT;
                w.target = STEP_IDLE;
            end
            default: begin
                w.seq    = SEQ_GOTO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // clamp a wide signed value into the coordinate range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(64'sd2147483647);
        lo = PROD_W'(-64'sd2147483648);
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- design/mandelbrot_escape_time_unit.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time count for one pixel, run by a microcoded sequencer over one
// shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// one pixel at a time: the next pixel is taken only after the last result has been
//   loaded into the output register; each z update takes four steps of
//   the single shared multiplier (zr*zr, zi*zi, zr*zi, then the update)
// a finished result waits in the output register while the next pixel starts
// reset (synchronous, active low): sequencer to idle, output empty, window
//   registers to their default view, limit 200
module mandelbrot_escape_time_unit
    import mbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
    // result output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // out_x[9:0], out_y[19:10],
                                                 // iteration_count[35:20], palette_color[39:36]
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data
);

    // configuration registers
    logic signed [COORD_W-1:0]    r_real_min;
    logic signed [COORD_W-1:0]    r_imag_min;
    logic        [STEP_REG_W-1:0] r_real_step;
    logic        [STEP_REG_W-1:0] r_imag_step;
    logic        [ITER_W-1:0]     r_max_iter;

    // sequencer
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_uw;

    // datapath
    logic        [PIX_W-1:0]   r_px;
    logic        [PIX_W-1:0]   r_py;
    logic signed [COORD_W-1:0] r_cr;
    logic signed [COORD_W-1:0] r_ci;
    logic signed [COORD_W-1:0] r_zr;
    logic signed [COORD_W-1:0] r_zi;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_sq_r;
    logic signed [PROD_W-1:0]  r_diff;
    logic        [ITER_W-1:0]  r_k;
    logic signed [COORD_W-1:0] w_mul_a;
    logic signed [COORD_W-1:0] w_mul_b;
    logic        [PROD_W-1:0]  w_mag;
    logic                      w_exit;
    logic                      w_in_xfer;
    logic                      w_out_load;

    // output register
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_x;
    logic [PIX_W-1:0]  r_out_y;
    logic [ITER_W-1:0] r_out_k;

    assign w_uw = mbe_ucode(r_step);

    // new pixels only enter at the idle step
    assign s_axis_tready = (w_uw.seq == SEQ_WAIT_IN);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // result slot is free when empty or being drained this cycle
    assign w_out_load = (w_uw.seq == SEQ_EMIT) && (!r_out_valid || m_axis_tready);

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (w_uw.mul_sel)
            MUL_NONE: begin
            end
            MUL_PX_RSTEP: begin
                w_mul_a = $signed(COORD_W'(r_px));
                w_mul_b = $signed(COORD_W'(r_real_step));
            end
            MUL_PY_ISTEP: begin
                w_mul_a = $signed(COORD_W'(r_py));
                w_mul_b = $signed(COORD_W'(r_imag_step));
            end
            MUL_ZR_ZR: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            MUL_ZI_ZI: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            MUL_ZR_ZI: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
            default: begin
            end
        endcase
    end

    // |z|^2 of the current z: zr^2 held in r_sq_r, zi^2 just landed in r_prod
    assign w_mag  = $unsigned(r_sq_r) + $unsigned(r_prod);
    // no exit before the first update; count saturates at the limit
    assign w_exit = (r_k != '0) && ((r_k >= r_max_iter) || (w_mag > ESC_THR));

    // step counter with conditional jumps
    always_comb begin
        n_step = r_step;
        unique case (w_uw.seq)
            SEQ_NEXT: begin
                n_step = r_step + 1'b1;
            end
            SEQ_WAIT_IN: begin
                if (w_in_xfer) begin
                    n_step = r_step + 1'b1;
                end
            end
            SEQ_EXIT: begin
                n_step = w_exit ? w_uw.target : r_step + 1'b1;
            end
            SEQ_GOTO: begin
                n_step = w_uw.target;
            end
            SEQ_EMIT: begin
                if (w_out_load) begin
                    n_step = w_uw.target;
                end
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_min  <= -32'sd200285062;
            r_imag_min  <= 32'sd30054034;
            r_real_step <= 31'd777;
            r_imag_step <= 31'd1100;
            r_max_iter  <= 16'd200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REAL_MIN:  r_real_min  <= i_cfg_data;
                REG_IMAG_MIN:  r_imag_min  <= i_cfg_data;
                REG_REAL_STEP: r_real_step <= i_cfg_data[STEP_REG_W-1:0];
                REG_IMAG_STEP: r_imag_step <= i_cfg_data[STEP_REG_W-1:0];
                REG_MAX_ITER:  r_max_iter  <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath, driven by the control word
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_in_xfer) begin
            r_px <= s_axis_tdata[PIX_W-1:0];
            r_py <= s_axis_tdata[2*PIX_W-1:PIX_W];
        end
        // c = min + pixel * step, clamped
        if (w_uw.ld_cr) begin
            r_cr <= sat32(PROD_W'(r_real_min) + r_prod);
        end
        if (w_uw.ld_ci) begin
            r_ci <= sat32(PROD_W'(r_imag_min) + r_prod);
            r_zr <= '0;
            r_zi <= '0;
            r_k  <= '0;
        end
        if (w_uw.ld_sq) begin
            r_sq_r <= r_prod;
        end
        // zr^2 - zi^2, each floored back to the coordinate scale
        if (w_uw.ld_diff) begin
            r_diff <= (r_sq_r >>> FRACTION_BITS) - (r_prod >>> FRACTION_BITS);
        end
        // z = z*z + c; r_prod holds zr*zi, scaled by one bit less for the doubling
        if (w_uw.upd_z) begin
            r_zr <= sat32(r_diff + PROD_W'(r_cr));
            r_zi <= sat32((r_prod >>> (FRACTION_BITS - 1)) + PROD_W'(r_ci));
            r_k  <= r_k + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_x <= r_px;
            r_out_y <= r_py;
            r_out_k <= r_k;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_k[COLOR_W-1:0], r_out_k, r_out_y, r_out_x};

endmodule

// ----- design/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks for the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker
    import mbe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // palette color is the low nibble of the count
    a_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:36] == m_axis_tdata[23:20])
        else $error("palette color does not match count");

    // at least one update per pixel
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[35:20] != 16'd0)
        else $error("zero iteration count");

    // one pixel at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a pixel is in flight");

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/mandelbrot_escape_time_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit_checker
// Watches the pixel, result and configuration channels of the escape-time
// unit. It keeps its own copy of the window registers, predicts every result
// from each accepted pixel and compares it with the result stream in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_checker
    import mbe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  logic [23:0]          i_pix_data,     // pixel_x[9:0], pixel_y[19:10]
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [39:0]          i_res_data,     // out_x, out_y, iteration_count, palette_color
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;
    localparam int     PALETTE_SIZE = 16;

    // window after reset
    localparam logic signed [COORD_W-1:0] RST_REAL_MIN  = -32'sd200285062;
    localparam logic signed [COORD_W-1:0] RST_IMAG_MIN  = 32'sd30054034;
    localparam logic [STEP_REG_W-1:0]     RST_REAL_STEP = 31'd777;
    localparam logic [STEP_REG_W-1:0]     RST_IMAG_STEP = 31'd1100;
    localparam logic [ITER_W-1:0]         RST_ITER_LIM  = 16'd200;

    // same bit order as the result tdata, highest field first
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ITER_W-1:0]  count;
        logic [PIX_W-1:0]   y;
        logic [PIX_W-1:0]   x;
    } t_pix_result;

    logic signed [COORD_W-1:0] real_min;
    logic signed [COORD_W-1:0] imag_min;
    logic [STEP_REG_W-1:0]     real_step;
    logic [STEP_REG_W-1:0]     imag_step;
    logic [ITER_W-1:0]         iter_limit;

    t_pix_result pending_pixels[$];

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return COORD_W'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            return COORD_W'(COORD_MIN);
        end
        return COORD_W'(v);
    endfunction

    function automatic t_pix_result escape_time_of(input logic [PIX_W-1:0] px,
                                                   input logic [PIX_W-1:0] py);
        longint      cr;
        longint      ci;
        longint      zr;
        longint      zi;
        longint      re_sq;
        longint      im_sq;
        longint      cross_term;
        logic [63:0] mag;
        int unsigned n;
        t_pix_result r;
        cr = clamp_coord(longint'(real_min) + longint'(px) * longint'(real_step));
        ci = clamp_coord(longint'(imag_min) + longint'(py) * longint'(imag_step));
        zr = 0;
        zi = 0;
        n  = 0;
        // z = z*z + c, products floored back to the coordinate scale
        do begin
            re_sq      = (zr * zr) >>> FRACTION_BITS;
            im_sq      = (zi * zi) >>> FRACTION_BITS;
            cross_term = (zr * zi) >>> (FRACTION_BITS - 1);
            zr         = clamp_coord(re_sq - im_sq + cr);
            zi         = clamp_coord(cross_term + ci);
            n++;
            mag        = 64'(zr * zr) + 64'(zi * zi);
        end while (n < iter_limit && mag <= ESC_THR);
        r.x     = px;
        r.y     = py;
        r.count = ITER_W'(n);
        r.color = COLOR_W'(n % PALETTE_SIZE);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_pix_result got;
        t_pix_result want;
        if (!i_rst_n) begin
            real_min     = RST_REAL_MIN;
            imag_min     = RST_IMAG_MIN;
            real_step    = RST_REAL_STEP;
            imag_step    = RST_IMAG_STEP;
            iter_limit   = RST_ITER_LIM;
            o_fail_count = 0;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_REAL_MIN:  real_min   = i_cfg_data;
                    REG_IMAG_MIN:  imag_min   = i_cfg_data;
                    REG_REAL_STEP: real_step  = i_cfg_data[STEP_REG_W-1:0];
                    REG_IMAG_STEP: imag_step  = i_cfg_data[STEP_REG_W-1:0];
                    REG_MAX_ITER:  iter_limit = i_cfg_data[ITER_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = t_pix_result'(i_res_data);
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d count=%0d color=%0d",
                             $time, got.x, got.y, got.count, got.color);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch expected x=%0d y=%0d count=%0d color=%0d",
                                 $time, want.x, want.y, want.count, want.color);
                        $display("%0t:                   actual x=%0d y=%0d count=%0d color=%0d",
                                 $time, got.x, got.y, got.count, got.color);
                        o_fail_count++;
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                pending_pixels.push_back(escape_time_of(i_pix_data[PIX_W-1:0],
                                                        i_pix_data[2*PIX_W-1:PIX_W]));
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

// ----- verif/mandelbrot_escape_time_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit_tb
// Drives pixels and window settings into the escape-time unit with random
// gaps and back-pressure; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_tb;
    import mbe_pkg::*;

    localparam int RUN_LIMIT     = 3_000_000;  // cycles before the run is declared hung
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PCT      = 32;
    localparam int HOLD_CYCLES   = 2000;       // long receiver stall for back-pressure
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int PIX_MAX       = (1 << PIX_W) - 1;
    localparam int ITER_MAX      = (1 << ITER_W) - 1;

    // fixed-point landmarks
    localparam int FX_ONE       = 1 << FRACTION_BITS;
    localparam int FX_TWO       = 2 * FX_ONE;
    localparam int VIEW_RE_MIN  = -FX_TWO;                   // -2.0
    localparam int VIEW_IM_MIN  = -(5 * FX_ONE) / 4;         // -1.25
    localparam int VIEW_RE_STEP = (3 * FX_ONE) >> PIX_W;     // 3.0 across the row
    localparam int VIEW_IM_STEP = (5 * FX_ONE / 2) >> PIX_W; // 2.5 down the column
    localparam int SEAHORSE_RE  = -(3 * FX_ONE) / 4;         // -0.75
    localparam int SEAHORSE_IM  = FX_ONE / 10;               // 0.1

    // window flavors for the random phases
    typedef enum int {
        WIN_FULL_VIEW,
        WIN_ANYTHING,
        WIN_SEAHORSE,
        WIN_WANDER
    } t_window_kind;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = REG_REAL_MIN;
    logic [COORD_W-1:0]   i_cfg_data    = '0;

    int   fail_count;
    int   pending_count;
    int   cycle_count   = 0;
    logic quiet         = 1'b0;  // both sides stop idling
    logic pressure_on   = 1'b0;  // ask the receiver for its long stall
    logic hold_served   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mandelbrot_escape_time_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    mandelbrot_escape_time_unit_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (s_axis_tvalid),
        .i_pix_ready  (s_axis_tready),
        .i_pix_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // hung-run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("mandelbrot_escape_time_unit_tb NOT OK");
            $finish;
        end
    end

    // result receiver: random stalls, one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (pressure_on && !hold_served) begin
                hold_served   = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one register write per cycle, enable left high for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
    endtask

    // whole window plus a write to an unused index; unused bits get random fill
    task automatic load_window(input logic [31:0] rmin, input logic [31:0] imin,
                               input logic [31:0] rstep, input logic [31:0] istep,
                               input int lim);
        write_reg(REG_REAL_MIN, rmin);
        write_reg(REG_IMAG_MIN, imin);
        write_reg(REG_REAL_STEP, rstep | (32'($urandom_range(1)) << STEP_REG_W));
        write_reg(REG_IMAG_STEP, istep | (32'($urandom_range(1)) << STEP_REG_W));
        write_reg(REG_MAX_ITER, {16'($urandom), 16'(lim)});
        write_reg(CFG_IDX_W'($urandom_range(7, int'(REG_MAX_ITER) + 1)), $urandom);
        i_cfg_we = 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0000, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // window writes only once every result is back
    task automatic wait_idle;
        s_axis_tvalid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_window_kind kind;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset window: the four corners
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(0, PIX_MAX);
        send_pixel(PIX_MAX, 0);

        // register extremes: zero limit behaves as one, coordinates saturate high or sit at the lowest value
        wait_idle();
        load_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_pixel(0, 0);
        send_pixel(PIX_MAX, PIX_MAX);
        send_pixel(PIX_MAX, 0);
        send_pixel(0, PIX_MAX);

        // c = 2.0 sits exactly on |z|^2 = 4 and escapes on the second update,
        // one step further out it escapes on the first
        wait_idle();
        load_window(FX_TWO, 0, 1, 0, ITER_MAX);
        send_pixel(0, PIX_W'($urandom));
        send_pixel(1, 0);

        // c = -2.0 is a fixed cycle on the boundary: runs to the top limit
        wait_idle();
        load_window(-FX_TWO, 0, 0, 0, ITER_MAX);
        send_pixel(PIX_MAX, PIX_MAX);

        // smallest nonzero limit over the full view
        wait_idle();
        load_window(VIEW_RE_MIN, VIEW_IM_MIN, VIEW_RE_STEP, VIEW_IM_STEP, 1);
        send_pixel(PIX_MAX / 2, PIX_MAX / 2);
        send_pixel(PIX_MAX, PIX_MAX / 2);

        // random phases, each with its own window
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            kind = t_window_kind'(phase % 4);
            case (kind)
                WIN_FULL_VIEW: begin
                    load_window(VIEW_RE_MIN, VIEW_IM_MIN, VIEW_RE_STEP, VIEW_IM_STEP,
                                $urandom_range(2, 48));
                end
                WIN_ANYTHING: begin
                    load_window($urandom, $urandom, $urandom, $urandom,
                                $urandom_range(1, 40));
                end
                WIN_SEAHORSE: begin
                    load_window(SEAHORSE_RE + int'($urandom_range(0, 1 << 22)),
                                SEAHORSE_IM + int'($urandom_range(0, 1 << 22)),
                                $urandom_range(0, 4096), $urandom_range(0, 4096),
                                $urandom_range(50, 200));
                end
                default: begin
                    load_window(VIEW_RE_MIN + int'($urandom_range(0, 5 * FX_ONE / 2)),
                                VIEW_IM_MIN + int'($urandom_range(0, 5 * FX_ONE / 2)),
                                $urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                                $urandom_range(1, 120));
                end
            endcase
            // second phase fills the unit against a stalled receiver,
            // third runs both sides flat out
            pressure_on = (phase == 1);
            quiet       = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(PIX_W'($urandom), PIX_W'($urandom));
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("mandelbrot_escape_time_unit_tb OK");
        end else begin
            $display("mandelbrot_escape_time_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
